/* hdl/ath_pkg.sv */
// shared types, constants and lookup functions for the atascii to html transcoder
// no dependencies; compiled first
`default_nettype none

package ath_pkg;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_EOL = 1'b0;
   localparam logic [7:0] EOL_RESET = 8'd155;

   localparam int QUEUE_DEPTH = 2;

   localparam int SPAN_OPEN_LEN  = 18;
   localparam int SPAN_CLOSE_LEN = 7;
   localparam int SEQ_IDX_W      = $clog2(SPAN_OPEN_LEN);

   localparam int BCD_DIGITS = 5;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int NDIG_W     = 3;

   // one queued job: what the back end has to spell out for one input
   typedef struct packed {
      logic              close;
      logic              open;
      logic              crlf;
      logic              entity;
      logic [NDIG_W-1:0] ndig;
      logic [BCD_W-1:0]  bcd;
      logic [6:0]        ch;
   } ath_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ath_q_status_type;

   // glyph entity numbers in bcd, zero means the code is written raw
   function automatic logic [BCD_W-1:0] glyph_bcd(input logic [6:0] code);
      logic [BCD_W-1:0] v;
      case (code)
         7'd0:    v = 20'h09829;
         7'd1:    v = 20'h09500;
         7'd2:    v = 20'h09621;
         7'd3:    v = 20'h09496;
         7'd4:    v = 20'h09508;
         7'd5:    v = 20'h09488;
         7'd6:    v = 20'h09585;
         7'd7:    v = 20'h09586;
         7'd8:    v = 20'h09698;
         7'd9:    v = 20'h09623;
         7'd10:   v = 20'h09699;
         7'd11:   v = 20'h09629;
         7'd12:   v = 20'h09624;
         7'd13:   v = 20'h09620;
         7'd14:   v = 20'h09601;
         7'd15:   v = 20'h09622;
         7'd16:   v = 20'h09827;
         7'd17:   v = 20'h09484;
         7'd18:   v = 20'h09472;
         7'd19:   v = 20'h09532;
         7'd20:   v = 20'h11044;
         7'd21:   v = 20'h09604;
         7'd22:   v = 20'h09615;
         7'd23:   v = 20'h09516;
         7'd24:   v = 20'h09524;
         7'd25:   v = 20'h09612;
         7'd26:   v = 20'h09492;
         7'd27:   v = 20'h08455;
         7'd28:   v = 20'h08593;
         7'd29:   v = 20'h08595;
         7'd30:   v = 20'h08592;
         7'd31:   v = 20'h08594;
         7'd38:   v = 20'h00038;
         7'd60:   v = 20'h00060;
         7'd62:   v = 20'h00062;
         7'd96:   v = 20'h09830;
         7'd123:  v = 20'h09824;
         7'd124:  v = 20'h09475;
         7'd125:  v = 20'h08598;
         7'd126:  v = 20'h09658;
         7'd127:  v = 20'h09668;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] span_open_char(input logic [SEQ_IDX_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = "<";
         5'd1:    c = "s";
         5'd2:    c = "p";
         5'd3:    c = "a";
         5'd4:    c = "n";
         5'd5:    c = " ";
         5'd6:    c = "c";
         5'd7:    c = "l";
         5'd8:    c = "a";
         5'd9:    c = "s";
         5'd10:   c = "s";
         5'd11:   c = "=";
         5'd12:   c = "\"";
         5'd13:   c = "i";
         5'd14:   c = "n";
         5'd15:   c = "v";
         5'd16:   c = "\"";
         5'd17:   c = ">";
         default: c = "<";
      endcase
      return c;
   endfunction

   function automatic logic [7:0] span_close_char(input logic [SEQ_IDX_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = "<";
         5'd1:    c = "/";
         5'd2:    c = "s";
         5'd3:    c = "p";
         5'd4:    c = "a";
         5'd5:    c = "n";
         5'd6:    c = ">";
         default: c = "<";
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/ath_req_if.sv */
// input channel: one atascii byte or page eject per transfer
// no dependencies
`default_nettype none

interface ath_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   logic       last_in_record;

   modport source (output valid, op, data_byte, last_in_record, input ready);
   modport sink   (input valid, op, data_byte, last_in_record, output ready);
endinterface

`default_nettype wire

/* hdl/ath_rsp_if.sv */
// result channel: one html text byte per transfer
// no dependencies
`default_nettype none

interface ath_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_of_run;

   modport source (output valid, text_byte, last_of_run, input ready);
   modport sink   (input valid, text_byte, last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/ath_front.sv */
// front end: accepts input bytes, tracks inverse and skip state, queues jobs
// depends on ath_pkg and ath_req_if
`default_nettype none

module ath_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   ath_req_if.sink                     req,
   input  wire logic [7:0]             eol_code,
   input  wire ath_pkg::ath_q_status_type q_status,
   output      logic                   push,
   output      ath_pkg::ath_job_type   job
);
   import ath_pkg::*;

   logic inverse_on_ff, inverse_on_in;
   logic skipping_ff, skipping_in;
   logic accept;
   logic [BCD_W-1:0] bcd;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign bcd       = glyph_bcd(req.data_byte[6:0]);

   always_comb begin
      inverse_on_in = inverse_on_ff;
      skipping_in   = skipping_ff;
      push          = 1'b0;
      job.close     = 1'b0;
      job.open      = 1'b0;
      job.crlf      = 1'b0;
      job.entity    = bcd != '0;
      job.bcd       = bcd;
      job.ch        = req.data_byte[6:0];
      if (bcd[19:16] != 4'd0) begin
         job.ndig = 3'd5;
      end else if (bcd[15:12] != 4'd0) begin
         job.ndig = 3'd4;
      end else if (bcd[11:8] != 4'd0) begin
         job.ndig = 3'd3;
      end else if (bcd[7:4] != 4'd0) begin
         job.ndig = 3'd2;
      end else begin
         job.ndig = 3'd1;
      end
      if (accept) begin
         if (req.op) begin
            inverse_on_in = 1'b0;
         end else if (skipping_ff) begin
            if (req.last_in_record) begin
               skipping_in = 1'b0;
            end
         end else if (req.data_byte == eol_code) begin
            // end of line wins over the inverse test
            push          = 1'b1;
            job.close     = inverse_on_ff;
            job.crlf      = 1'b1;
            job.entity    = 1'b0;
            inverse_on_in = 1'b0;
            skipping_in   = !req.last_in_record;
         end else if (req.data_byte[7]) begin
            push          = 1'b1;
            job.open      = !inverse_on_ff;
            inverse_on_in = 1'b1;
         end else begin
            push          = 1'b1;
            job.close     = inverse_on_ff;
            inverse_on_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_on_ff <= 1'b0;
         skipping_ff   <= 1'b0;
      end else begin
         inverse_on_ff <= inverse_on_in;
         skipping_ff   <= skipping_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ath_queue.sv */
// short job queue between front and back end
// depends on ath_pkg
`default_nettype none

module ath_queue #(
   parameter int QueueDepth = ath_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ath_pkg::ath_job_type      din,
   input  wire logic                      pop,
   output      ath_pkg::ath_job_type      dout,
   output      ath_pkg::ath_q_status_type status
);
   import ath_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   ath_job_type mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = count_ff == CntW'(QueueDepth);
   assign status.empty = count_ff == '0;
   assign dout         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ath_back.sv */
// back end: spells out each queued job into an output register, one text byte per
// cycle unless rsp stalls; depends on ath_pkg and ath_rsp_if
`default_nettype none

module ath_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ath_pkg::ath_job_type      job,
   input  wire ath_pkg::ath_q_status_type q_status,
   output      logic                      pop,
   ath_rsp_if.source                      rsp
);
   import ath_pkg::*;

   typedef enum logic [9:0] {
      PH_START = 10'b00_0000_0001,
      PH_CLOSE = 10'b00_0000_0010,
      PH_OPEN  = 10'b00_0000_0100,
      PH_CR    = 10'b00_0000_1000,
      PH_LF    = 10'b00_0001_0000,
      PH_AMP   = 10'b00_0010_0000,
      PH_HASH  = 10'b00_0100_0000,
      PH_DIG   = 10'b00_1000_0000,
      PH_SEMI  = 10'b01_0000_0000,
      PH_RAW   = 10'b10_0000_0000
   } ath_phase_type;

   ath_phase_type phase_ff, phase_in, phase_cur, phase_nxt;
   logic [SEQ_IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] text_ff, text_in;
   logic last_ff, last_in;
   logic emit, seg_end, job_end;
   logic [NDIG_W-1:0] nib;
   logic [3:0] digit;
   logic [7:0] byte_cur;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.text_byte   = text_ff;
   assign rsp.last_of_run = last_ff;

   assign emit = !q_status.empty && (!rsp_valid_ff || rsp.ready);
   assign nib  = job.ndig - NDIG_W'(1) - idx_ff[NDIG_W-1:0];

   always_comb begin
      case (nib)
         3'd0:    digit = job.bcd[3:0];
         3'd1:    digit = job.bcd[7:4];
         3'd2:    digit = job.bcd[11:8];
         3'd3:    digit = job.bcd[15:12];
         3'd4:    digit = job.bcd[19:16];
         default: digit = 4'd0;
      endcase
   end

   // a fresh head job picks its first phase straight from its flags
   always_comb begin
      if (phase_ff != PH_START) begin
         phase_cur = phase_ff;
      end else if (job.close) begin
         phase_cur = PH_CLOSE;
      end else if (job.open) begin
         phase_cur = PH_OPEN;
      end else if (job.crlf) begin
         phase_cur = PH_CR;
      end else if (job.entity) begin
         phase_cur = PH_AMP;
      end else begin
         phase_cur = PH_RAW;
      end
   end

   always_comb begin
      byte_cur  = {1'b0, job.ch};
      seg_end   = 1'b1;
      job_end   = 1'b0;
      phase_nxt = PH_START;
      case (phase_cur)
         PH_CLOSE: begin
            byte_cur  = span_close_char(idx_ff);
            seg_end   = idx_ff == SEQ_IDX_W'(SPAN_CLOSE_LEN - 1);
            phase_nxt = job.crlf ? PH_CR : (job.entity ? PH_AMP : PH_RAW);
         end
         PH_OPEN: begin
            byte_cur  = span_open_char(idx_ff);
            seg_end   = idx_ff == SEQ_IDX_W'(SPAN_OPEN_LEN - 1);
            phase_nxt = job.entity ? PH_AMP : PH_RAW;
         end
         PH_CR: begin
            byte_cur  = 8'h0D;
            phase_nxt = PH_LF;
         end
         PH_LF: begin
            byte_cur = 8'h0A;
            job_end  = 1'b1;
         end
         PH_AMP: begin
            byte_cur  = "&";
            phase_nxt = PH_HASH;
         end
         PH_HASH: begin
            byte_cur  = "#";
            phase_nxt = PH_DIG;
         end
         PH_DIG: begin
            byte_cur  = {4'h3, digit};
            seg_end   = idx_ff == SEQ_IDX_W'(job.ndig - NDIG_W'(1));
            phase_nxt = PH_SEMI;
         end
         PH_SEMI: begin
            byte_cur = ";";
            job_end  = 1'b1;
         end
         PH_RAW: begin
            byte_cur = {1'b0, job.ch};
            job_end  = 1'b1;
         end
         default: begin
            byte_cur = {1'b0, job.ch};
            job_end  = 1'b1;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      text_in      = text_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         text_in      = byte_cur;
         last_in      = job_end;
         if (job_end) begin
            phase_in = PH_START;
            idx_in   = '0;
            pop      = 1'b1;
         end else if (seg_end) begin
            phase_in = phase_nxt;
            idx_in   = '0;
         end else begin
            phase_in = phase_cur;
            idx_in   = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      text_ff <= text_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

/* hdl/atascii_to_html_transcoder.sv */
// atascii to html transcoder top level: csr register, front end, job queue, back end
// depends on ath_pkg, ath_req_if, ath_rsp_if, ath_front, ath_queue, ath_back
//
//   port   dir  protocol       payload
//   req    in   valid/ready    op, data_byte, last_in_record
//   rsp    out  valid/ready    text_byte, last_of_run
//   csr    in   apb, 32 bit    eol_code at byte address 0
//
// the back end sends one text byte per cycle unless rsp stalls, and an input produces
// 1 to 26 bytes (span open plus a five digit entity)
// inputs that produce nothing (page eject, skipped bytes) end in the front end and queue no job
// a job queue of QueueDepth entries sits between front and back; req.ready drops when full
// synchronous reset clears inverse and skip state and sets eol_code to 155; no clearing pass
`default_nettype none

module atascii_to_html_transcoder #(
   parameter int QueueDepth = ath_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ath_req_if.sink                                req,
   ath_rsp_if.source                              rsp,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ath_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ath_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [ath_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                              csr_pready
);
   import ath_pkg::*;

   logic [7:0] eol_code_ff, eol_code_in;
   logic csr_wr;
   logic push, pop;
   ath_job_type job_in, job_out;
   ath_q_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_ADDR_EOL);
   assign eol_code_in = csr_wr ? csr_pwdata[7:0] : eol_code_ff;
   assign csr_prdata  = (csr_paddr == CSR_ADDR_EOL)
                        ? {{(CSR_DATA_W - 8){1'b0}}, eol_code_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eol_code_ff <= EOL_RESET;
      end else begin
         eol_code_ff <= eol_code_in;
      end
   end

   ath_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .eol_code (eol_code_ff),
      .q_status (q_status),
      .push     (push),
      .job      (job_in)
   );

   ath_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .din    (job_in),
      .pop    (pop),
      .dout   (job_out),
      .status (q_status)
   );

   ath_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job      (job_out),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

/* hdl/ath_checker.sv */
// port level checks for the transcoder top level, with the bind that attaches them
// depends on ath_pkg and atascii_to_html_transcoder
`default_nettype none

module ath_port_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [7:0]                     text_byte,
   input wire logic                           last_of_run,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic [ath_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [ath_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [ath_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                           csr_pready
);
   import ath_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(text_byte) && $stable(last_of_run))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_eol_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_ADDR_EOL)
      ##1 (csr_psel && !csr_pwrite && csr_paddr == CSR_ADDR_EOL)
      |-> csr_prdata == {{(CSR_DATA_W - 8){1'b0}}, $past(csr_pwdata[7:0])})
      else $error("eol_code readback differs from last write");

endmodule

bind atascii_to_html_transcoder ath_port_checker u_ath_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .text_byte   (rsp.text_byte),
   .last_of_run (rsp.last_of_run),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);

`default_nettype wire
